// ===== hdl/angle_frame_sync_checksum_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the angle frame synchroniser
// Short wrappers around concurrent assertions. Each one is clocked on the
// rising edge and is disabled while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef ANGLE_FRAME_SYNC_CHECKSUM_ASSERT_SVH
`define ANGLE_FRAME_SYNC_CHECKSUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// Angle frame synchroniser package
// Shared constants, the frame state encoding and the result record.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned PayLen   = 8;
  localparam int unsigned PayIdxW  = $clog2(PayLen);

  localparam logic [ByteW-1:0] HEADER_BYTE    = 8'h55;
  localparam logic [ByteW-1:0] TYPE_CODE_RST  = 8'h53;
  localparam logic [PayIdxW-1:0] PAY_IDX_LAST = PayIdxW'(PayLen - 1);

  typedef logic [ByteW-1:0] byte_t;
  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic [3:0] {
    ST_HEAD    = 4'b0001,
    ST_TYPE    = 4'b0010,
    ST_PAYLOAD = 4'b0100,
    ST_CHECK   = 4'b1000
  } frame_state_t;

  typedef struct packed {
    word_t roll;
    word_t pitch;
    word_t yaw;
    word_t temperature;
  } angle_res_t;

endpackage

// ===== hdl/afs_framer.sv =====
// ----------------------------------------------------------------------------
// Angle frame synchroniser: frame tracker
// Follows the byte stream one accepted item at a time, keeps the running
// checksum and the payload bytes, and flags a result on a good checksum.
// ----------------------------------------------------------------------------
`include "angle_frame_sync_checksum_assert.svh"

module afs_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  afs_pkg::byte_t      data_byte,
  input  afs_pkg::byte_t      type_code,
  output logic                res_valid,
  output afs_pkg::angle_res_t res
);
  import afs_pkg::*;

  frame_state_t       state_r, state_nxt;
  byte_t              sum_r, sum_nxt;
  logic [PayIdxW-1:0] idx_r, idx_nxt;
  byte_t              pay_r [PayLen];

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    res_valid = 1'b0;
    if (in_fire) begin
      unique case (state_r)
        ST_HEAD: begin
          if (data_byte == HEADER_BYTE) begin
            sum_nxt   = HEADER_BYTE;
            state_nxt = ST_TYPE;
          end
        end
        ST_TYPE: begin
          // The type check comes first so that a type code equal to the
          // header is still taken as the type byte.
          if (data_byte == type_code) begin
            sum_nxt   = 8'(sum_r + data_byte);
            idx_nxt   = '0;
            state_nxt = ST_PAYLOAD;
          end else if (data_byte == HEADER_BYTE) begin
            sum_nxt   = HEADER_BYTE;
            state_nxt = ST_TYPE;
          end else begin
            state_nxt = ST_HEAD;
          end
        end
        ST_PAYLOAD: begin
          sum_nxt = 8'(sum_r + data_byte);
          idx_nxt = idx_r + 1'b1;
          if (idx_r == PAY_IDX_LAST) begin
            state_nxt = ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_nxt = ST_HEAD;
          res_valid = (data_byte == sum_r);
        end
        default: begin
          state_nxt = ST_HEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEAD;
      sum_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && state_r == ST_PAYLOAD) begin
      pay_r[idx_r] <= data_byte;
    end
  end

  assign res.roll        = {pay_r[1], pay_r[0]};
  assign res.pitch       = {pay_r[3], pay_r[2]};
  assign res.yaw         = {pay_r[5], pay_r[4]};
  assign res.temperature = {pay_r[7], pay_r[6]};

  `AFS_ASSERT_SAME(a_res_only_on_check, clk, rst_n, res_valid, state_r == ST_CHECK, "result outside checksum phase")
  `AFS_ASSERT_NEXT(a_check_to_head, clk, rst_n, in_fire && state_r == ST_CHECK, state_r == ST_HEAD, "checksum byte did not end the frame")
  `AFS_ASSERT_NEXT(a_last_pay_to_check, clk, rst_n, in_fire && state_r == ST_PAYLOAD && idx_r == PAY_IDX_LAST, state_r == ST_CHECK && sum_r == $past(sum_nxt), "eighth payload byte did not reach the checksum phase")

endmodule

// ===== hdl/afs_out_reg.sv =====
// ----------------------------------------------------------------------------
// Angle frame synchroniser: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "angle_frame_sync_checksum_assert.svh"

module afs_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  afs_pkg::angle_res_t load_res,
  input  logic                out_stall,
  output logic                out_valid,
  output afs_pkg::angle_res_t out_res
);
  import afs_pkg::*;

  logic       valid_r, valid_nxt;
  angle_res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  `AFS_ASSERT_SAME(a_no_overwrite, clk, rst_n, load, !(valid_r && out_stall), "result overwritten while stalled")
  `AFS_ASSERT_NEXT(a_load_shows, clk, rst_n, load, valid_r && res_r == $past(load_res), "loaded result not presented")
  `AFS_ASSERT_NEXT(a_taken_clears, clk, rst_n, valid_r && !out_stall && !load, !valid_r, "taken result presented twice")

endmodule

// ===== hdl/angle_frame_sync_checksum.sv =====
// ----------------------------------------------------------------------------
// Angle frame synchroniser with additive checksum
// Finds 11-byte angle frames in a sensor byte stream and presents the four
// raw words of every frame whose checksum matches.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction  Moves
//  in        in_valid, in_stall, in_data_byte  sink       one received byte
//  out       out_valid, out_stall, out_*_raw   source     one decoded frame
//  cfg       cfg_wr_en, cfg_wr_data            sink       frame type code
//
// One byte is accepted every cycle while the input is not stalled; the frame
// tracker updates in the cycle of acceptance and a result appears in the
// result register in the cycle after its checksum byte is accepted.
// Reset returns the tracker to waiting for a header and the type code to
// 0x53; the payload bytes are not cleared.
// Input is stalled only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
module angle_frame_sync_checksum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  afs_pkg::byte_t        in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output afs_pkg::word_t        out_roll_raw,
  output afs_pkg::word_t        out_pitch_raw,
  output afs_pkg::word_t        out_yaw_raw,
  output afs_pkg::word_t        out_temperature_raw,
  input  logic                  cfg_wr_en,
  input  afs_pkg::byte_t        cfg_wr_data
);
  import afs_pkg::*;

  byte_t      type_code_r;
  logic       in_fire;
  logic       res_valid;
  angle_res_t res;
  angle_res_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_code_r <= TYPE_CODE_RST;
    end else if (cfg_wr_en) begin
      type_code_r <= cfg_wr_data;
    end
  end

  // A held result that is not being taken blocks the next byte.
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  afs_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_data_byte),
    .type_code (type_code_r),
    .res_valid (res_valid),
    .res       (res)
  );

  afs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_roll_raw        = out_res.roll;
  assign out_pitch_raw       = out_res.pitch;
  assign out_yaw_raw         = out_res.yaw;
  assign out_temperature_raw = out_res.temperature;

endmodule

// ===== tb/tb_angle_frame_sync_checksum.sv =====
// ----------------------------------------------------------------------------
// Testbench for the angle frame synchroniser
// Feeds byte streams built from good, corrupt, truncated and mistyped angle
// frames mixed with line noise, under several frame type codes. A scoreboard
// follows the byte stream to work out which frames must be decoded and
// checks every decoded result field by field, in order.
// ----------------------------------------------------------------------------
module tb_angle_frame_sync_checksum;
  timeunit 1ns;
  timeprecision 1ps;

  import afs_pkg::*;

  localparam int PH_HUNT     = 0;
  localparam int PH_TYPE     = 1;
  localparam int PH_PAY0     = 2;
  localparam int PH_CHECK    = 10;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_ITEMS = 220;
  localparam int QUIET_FROM  = 600;
  localparam int QUIET_TO    = 850;

  // Tracks the frame position of the byte stream and holds the decoded
  // results that are still to come out of the block.
  class frame_scoreboard;
    byte_t      type_code;
    int         phase;
    byte_t      sum;
    byte_t      payload [PayLen];
    angle_res_t frames_due [$];
    int         failures;

    function new();
      type_code = TYPE_CODE_RST;
      phase     = PH_HUNT;
      sum       = '0;
      failures  = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function void set_type_code(byte_t code);
      type_code = code;
    endfunction

    function void note_byte(byte_t b);
      angle_res_t res;
      if (phase == PH_TYPE) begin
        if (b == type_code) begin
          sum   = sum + b;
          phase = PH_PAY0;
        end else if (b == HEADER_BYTE) begin
          sum   = HEADER_BYTE;
          phase = PH_TYPE;
        end else begin
          phase = PH_HUNT;
        end
      end else if (phase >= PH_PAY0 && phase < PH_CHECK) begin
        payload[phase - PH_PAY0] = b;
        sum   = sum + b;
        phase = phase + 1;
      end else if (phase == PH_CHECK) begin
        // The checksum byte always ends the frame and is never a header.
        phase = PH_HUNT;
        if (b == sum) begin
          res.roll        = {payload[1], payload[0]};
          res.pitch       = {payload[3], payload[2]};
          res.yaw         = {payload[5], payload[4]};
          res.temperature = {payload[7], payload[6]};
          frames_due.push_back(res);
        end
      end else if (b == HEADER_BYTE) begin
        sum   = HEADER_BYTE;
        phase = PH_TYPE;
      end else begin
        phase = PH_HUNT;
      end
    endfunction

    function void check_frame(angle_res_t got);
      angle_res_t want;
      if (frames_due.size() == 0) begin
        flag($sformatf("unexpected frame: roll %0d pitch %0d yaw %0d temp %0d",
                       got.roll, got.pitch, got.yaw, got.temperature));
        return;
      end
      want = frames_due.pop_front();
      if (got.roll !== want.roll || got.pitch !== want.pitch ||
          got.yaw !== want.yaw || got.temperature !== want.temperature) begin
        flag($sformatf({"frame mismatch: expected roll %0d pitch %0d yaw %0d temp %0d,",
                        " got roll %0d pitch %0d yaw %0d temp %0d"},
                       want.roll, want.pitch, want.yaw, want.temperature,
                       got.roll, got.pitch, got.yaw, got.temperature));
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n        = 1'b0;
  logic   in_valid     = 1'b0;
  logic   in_stall;
  byte_t  in_data_byte = '0;
  logic   out_valid;
  logic   out_stall    = 1'b0;
  word_t  out_roll_raw;
  word_t  out_pitch_raw;
  word_t  out_yaw_raw;
  word_t  out_temperature_raw;
  logic   cfg_wr_en    = 1'b0;
  byte_t  cfg_wr_data  = '0;

  frame_scoreboard sb = new();
  byte_t cur_code   = TYPE_CODE_RST;
  bit    quiet      = 1'b0;
  int    items_sent = 0;
  int    idle_cycles = 0;

  angle_frame_sync_checksum u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_roll_raw        (out_roll_raw),
    .out_pitch_raw       (out_pitch_raw),
    .out_yaw_raw         (out_yaw_raw),
    .out_temperature_raw (out_temperature_raw),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  // Accepted items are noted before results are checked, so a result can
  // never be compared ahead of the byte that produced it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data_byte);
      if (out_valid && !out_stall) begin
        sb.check_frame({out_roll_raw, out_pitch_raw, out_yaw_raw, out_temperature_raw});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_byte(input byte_t b);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    quiet <= (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
  endtask

  // Sends a complete frame; a non-zero offset corrupts the checksum byte.
  task automatic send_frame(input byte_t code, input logic [63:0] pay, input byte_t offset);
    byte_t chk;
    chk = HEADER_BYTE + code;
    send_byte(HEADER_BYTE);
    send_byte(code);
    for (int i = 0; i < PayLen; i++) begin
      send_byte(pay[8*i +: 8]);
      chk = chk + pay[8*i +: 8];
    end
    send_byte(chk + offset);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_type_code(input byte_t code);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_type_code(code);
    cur_code = code;
  endtask

  function automatic logic [63:0] random_payload();
    logic [63:0] pay;
    pay = {$urandom(), $urandom()};
    for (int i = 0; i < PayLen; i++) begin
      case ($urandom_range(15))
        0: pay[8*i +: 8] = 8'h00;
        1: pay[8*i +: 8] = 8'hFF;
        2: pay[8*i +: 8] = 8'h80;
        3: pay[8*i +: 8] = 8'h7F;
        default: ;
      endcase
    end
    return pay;
  endfunction

  task automatic random_traffic(input int count);
    int          stop_at;
    int          pick;
    int          cut;
    byte_t       acc;
    byte_t       b;
    logic [63:0] pay;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pay = random_payload();
        if ($urandom_range(9) == 0) begin
          // Make the checksum byte itself look like a header.
          acc = HEADER_BYTE + cur_code;
          for (int i = 0; i < PayLen - 1; i++) acc = acc + pay[8*i +: 8];
          pay[63:56] = HEADER_BYTE - acc;
        end
        send_frame(cur_code, pay, 8'h00);
      end else if (pick < 78) begin
        send_frame(cur_code, random_payload(), byte_t'($urandom_range(1, 255)));
      end else if (pick < 84) begin
        pay = random_payload();
        cut = $urandom_range(0, PayLen - 1);
        send_byte(HEADER_BYTE);
        send_byte(cur_code);
        for (int i = 0; i < cut; i++) send_byte(pay[8*i +: 8]);
      end else if (pick < 88) begin
        do b = byte_t'($urandom_range(255)); while (b == cur_code);
        send_byte(HEADER_BYTE);
        send_byte(b);
      end else begin
        b = ($urandom_range(9) < 4) ? HEADER_BYTE : byte_t'($urandom_range(255));
        send_byte(b);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Noise, a mistyped frame, a header in the type slot, then a good frame.
    send_byte(8'h12);
    send_byte(HEADER_BYTE);
    send_byte(8'h00);
    send_byte(HEADER_BYTE);
    send_frame(cur_code, 64'hAA55_FE01_7FFF_8000, 8'h00);
    // A failing frame whose checksum byte is the header value.
    send_frame(cur_code, 64'h0, HEADER_BYTE - (HEADER_BYTE + cur_code));

    random_traffic(PHASE_ITEMS);
    write_type_code(8'h00);
    random_traffic(PHASE_ITEMS);
    write_type_code(8'hFF);
    random_traffic(PHASE_ITEMS);
    write_type_code(HEADER_BYTE);
    random_traffic(PHASE_ITEMS);
    write_type_code(byte_t'($urandom_range(255)));
    random_traffic(PHASE_ITEMS);
    write_type_code(TYPE_CODE_RST);
    random_traffic(PHASE_ITEMS);

    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/afs_pkg.sv
hdl/afs_framer.sv
hdl/afs_out_reg.sv
hdl/angle_frame_sync_checksum.sv
tb/tb_angle_frame_sync_checksum.sv
